// ----- sv/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Shared constants, operation codes and the sequencer state type for the
// crossing-number point-in-polygon block.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

	// Width of the vertex count register.
	localparam int COUNT_BITS = 7;

	// Width of the vertex index field.
	localparam int INDEX_BITS = 6;

	// Number of vertex slots in the store.
	localparam int MAX_VERTICES = 64;

	// A polygon needs at least this many vertices to enclose anything.
	localparam int MIN_POLY_VERTICES = 3;

	// Cycles from the last vertex read until its edge result lands in the flag.
	localparam int PIPE_DEPTH = 4;
	localparam int DRAIN_BITS = $clog2(PIPE_DEPTH);

	// Operation codes of an input transaction.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} state_t;

endpackage : pip_pkg

`default_nettype wire

// ----- sv/pip_edge_unit.sv -----
// ----------------------------------------------------------------------------
// Point-in-polygon edge test unit
// Pipelined test of one polygon edge per cycle: does the edge straddle the
// point's y, and does the point lie strictly left of the truncated crossing x.
// The division is replaced by exact cross-multiplied comparisons.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_edge_unit
	import pip_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           edge_valid,
	input  wire logic signed [COORD_BITS-1:0] px,
	input  wire logic signed [COORD_BITS-1:0] py,
	input  wire logic signed [COORD_BITS-1:0] x1,
	input  wire logic signed [COORD_BITS-1:0] y1,
	input  wire logic signed [COORD_BITS-1:0] x2,
	input  wire logic signed [COORD_BITS-1:0] y2,
	output logic                          hit
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * COORD_BITS;
	localparam int RW = 2 * COORD_BITS + 1;

	// Magnitude of a difference; always fits in COORD_BITS unsigned bits.
	function automatic logic [COORD_BITS-1:0] mag(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] t;
		t = v[DW-1] ? -v : v;
		return t[COORD_BITS-1:0];
	endfunction

	logic signed [DW-1:0] a, b, c, d;
	logic [DW-1:0] d_inc;
	logic straddle;

	logic v_s2, straddle_s2, sgn_s2, dneg_s2;
	logic [COORD_BITS-1:0] ma_s2, mb_s2, mc_s2;
	logic [DW-1:0] mm_s2;

	logic v_s3, sgn_s3, dneg_s3;
	logic [PW-1:0] p_s3;
	logic [RW-1:0] r_s3;
	logic [COORD_BITS-1:0] mc_s3;

	logic q_nonzero, neg, left;
	logic hit_s4;

	// Differences at one extra bit so nothing overflows.
	always_comb begin
		a = $signed({x2[COORD_BITS-1], x2}) - $signed({x1[COORD_BITS-1], x1});
		b = $signed({py[COORD_BITS-1], py}) - $signed({y1[COORD_BITS-1], y1});
		c = $signed({y2[COORD_BITS-1], y2}) - $signed({y1[COORD_BITS-1], y1});
		d = $signed({px[COORD_BITS-1], px}) - $signed({x1[COORD_BITS-1], x1});
		d_inc = d + DW'(1);
		straddle = (y1 > py) != (y2 > py);
	end

	// Stage 2: magnitudes, signs and the straddle test.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= edge_valid;
		end
	end

	always_ff @(posedge clk) begin
		straddle_s2 <= straddle;
		sgn_s2      <= a[DW-1] ^ b[DW-1] ^ c[DW-1];
		dneg_s2     <= d[DW-1];
		ma_s2       <= mag(a);
		mb_s2       <= mag(b);
		mc_s2       <= mag(c);
		// For a negative offset keep its magnitude, otherwise offset plus one.
		mm_s2       <= d[DW-1] ? {1'b0, mag(d)} : d_inc;
	end

	// Stage 3: the two products of the cross-multiplied comparison.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2 && straddle_s2;
		end
	end

	always_ff @(posedge clk) begin
		sgn_s3  <= sgn_s2;
		dneg_s3 <= dneg_s2;
		p_s3    <= PW'(ma_s2) * PW'(mb_s2);
		r_s3    <= RW'(mm_s2) * RW'(mc_s2);
		mc_s3   <= mc_s2;
	end

	// The truncated quotient is negative only when it is nonzero and the
	// operand signs disagree. Then the point is left when its offset exceeds
	// the quotient's magnitude; otherwise when the offset is below it.
	always_comb begin
		q_nonzero = p_s3 >= PW'(mc_s3);
		neg       = sgn_s3 && q_nonzero;
		if (neg) begin
			left = dneg_s3 && (RW'(p_s3) < r_s3);
		end else begin
			left = dneg_s3 || (r_s3 <= RW'(p_s3));
		end
	end

	// Stage 4: registered crossing result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s4 <= 1'b0;
		end else begin
			hit_s4 <= v_s3 && left;
		end
	end

	assign hit = hit_s4;

endmodule : pip_edge_unit

`default_nettype wire

// ----- sv/point_in_polygon_test.sv -----
// ----------------------------------------------------------------------------
// Point-in-polygon test
// Crossing-number test of a query point against a stored polygon.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_ready) carries two kinds of transaction. A
// write (opcode 0) stores x_coord/y_coord at vertex_index and gives no
// result. A query (opcode 1) tests the point x_coord/y_coord and gives one
// inside_res on the output channel (out_valid/out_ready). A query walks the
// edges through a pipelined edge test unit at one edge per cycle: n + 1
// vertex reads, a drain of the edge pipeline and a load of the result.
// out_valid rises and in_ready returns at the same edge. With fewer than
// three vertices the answer is outside. vertex_count is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while idle, as the
// block does not enforce this. Reset clears the count, the sequencer state
// and the valid flags; vertex memory must be written before it is read.
// While a result waits on out_ready, writes are still accepted; a following
// query runs and then holds its result and in_ready low until the output
// register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_test
	import pip_pkg::*;
#(
	parameter int COORD_BITS   = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_wr_en,
	input  wire logic [COUNT_BITS-1:0]       cfg_wr_data,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire logic                        opcode,
	input  wire logic [INDEX_BITS-1:0]       vertex_index,
	input  wire logic signed [COORD_BITS-1:0] x_coord,
	input  wire logic signed [COORD_BITS-1:0] y_coord,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic                             inside_res
);

	localparam int ADDR_W = $clog2(MAX_VERTICES);

	state_t state_q, state_next;

	logic [COUNT_BITS-1:0] vertex_count_q;
	logic [COUNT_BITS-1:0] n_eff;
	logic [COUNT_BITS-1:0] n_q;
	logic [COUNT_BITS-1:0] rd_cnt_q;
	logic [DRAIN_BITS-1:0] drain_q;

	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic inside_q;
	logic out_valid_q, inside_res_q;

	logic signed [COORD_BITS-1:0] mem_x_q [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] mem_y_q [MAX_VERTICES];

	logic [ADDR_W-1:0] rd_addr;
	logic rd_en, load_out, accept, accept_query, wr_vertex;

	logic v_s1, prime_s1;
	logic signed [COORD_BITS-1:0] rdx_s1, rdy_s1;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;

	logic edge_hit;

	// Vertex count register; counts above the store depth saturate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_wr_en) begin
			vertex_count_q <= cfg_wr_data;
		end
	end

	assign n_eff = (int'(vertex_count_q) > MAX_VERTICES) ? COUNT_BITS'(MAX_VERTICES)
		: vertex_count_q;

	assign accept       = in_valid && in_ready;
	assign accept_query = accept && (opcode == OP_QUERY);
	assign wr_vertex    = accept && (opcode == OP_WRITE) && (int'(vertex_index) < MAX_VERTICES);

	// Next-state logic of the query sequencer.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_query) begin
					state_next = (int'(n_eff) >= MIN_POLY_VERTICES) ? ST_SCAN : ST_FIN;
				end
			end
			ST_SCAN: begin
				if (rd_cnt_q == n_q) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q == DRAIN_BITS'(PIPE_DEPTH - 1)) begin
					state_next = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_SCAN:  rd_en    = 1'b1;
			ST_FIN:   load_out = !out_valid_q || out_ready;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Query context and edge walk counters.
	always_ff @(posedge clk) begin
		if (accept_query) begin
			px_q     <= x_coord;
			py_q     <= y_coord;
			n_q      <= n_eff;
			rd_cnt_q <= '0;
			drain_q  <= '0;
			inside_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + COUNT_BITS'(1);
			end
			if (state_q == ST_DRAIN) begin
				drain_q <= drain_q + DRAIN_BITS'(1);
			end
			if (edge_hit) begin
				inside_q <= !inside_q;
			end
		end
	end

	// The first read fetches the last vertex so that vertex 0 has its partner;
	// after that vertices are read in order.
	assign rd_addr = (rd_cnt_q == '0) ? ADDR_W'(n_q - COUNT_BITS'(1))
		: ADDR_W'(rd_cnt_q - COUNT_BITS'(1));

	// Vertex memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_vertex) begin
			mem_x_q[ADDR_W'(vertex_index)] <= x_coord;
			mem_y_q[ADDR_W'(vertex_index)] <= y_coord;
		end
		if (rd_en) begin
			rdx_s1 <= mem_x_q[rd_addr];
			rdy_s1 <= mem_y_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
		end
	end

	// The previous vertex read becomes the far end of the next edge.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			prime_s1 <= (rd_cnt_q == '0);
		end
		if (v_s1) begin
			prev_x_q <= rdx_s1;
			prev_y_q <= rdy_s1;
		end
	end

	pip_edge_unit #(
		.COORD_BITS (COORD_BITS)
	) u_edge (
		.clk        (clk),
		.arst_n     (arst_n),
		.edge_valid (v_s1 && !prime_s1),
		.px         (px_q),
		.py         (py_q),
		.x1         (rdx_s1),
		.y1         (rdy_s1),
		.x2         (prev_x_q),
		.y2         (prev_y_q),
		.hit        (edge_hit)
	);

	// Output register; a transaction leaves when out_ready is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			inside_res_q <= inside_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = inside_res_q;

endmodule : point_in_polygon_test

`default_nettype wire
